[rtl/ppp_pkg.sv]
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths, register codes and the transaction type that passes from
// the front part of the point projector to its back part.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_pkg;

  // field widths
  localparam int PtW   = 24;            // point coordinate, Q13.10
  localparam int PoseW = 16;            // pose entry, Q5.10
  localparam int KW    = 21;            // intrinsic entry, Q12.8
  localparam int PixW  = 20;            // pixel output
  localparam int CfgW  = 64;            // config write data
  localparam int IdxW  = 3;             // config register index
  localparam int KRowW = 3 * KW;        // packed intrinsic row

  // internal widths
  localparam int Pr1W = PoseW + PtW;    // pose product
  localparam int Sum1W = Pr1W + 2;      // sum of four pose products
  localparam int CamW = 32;             // camera point, Q.10, |c| <= 2^30
  localparam int Pr2W = KW + CamW;      // intrinsic product
  localparam int HW   = Pr2W + 2;       // image point, sum of three products
  localparam int NW   = HW + 1;         // 2|n| + |d| and 2|d|
  localparam int QW   = PixW;           // quotient bits resolved by the divider
  localparam int RW   = NW + QW + 1;    // partial remainder compare width

  // skid queue between front and back
  localparam int QDepth = 8;
  localparam int QAw    = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  // saturation limits
  localparam logic [QW-1:0] PixMaxMag = QW'((1 << (PixW - 1)) - 1);
  localparam logic [QW-1:0] PixMinMag = QW'(1 << (PixW - 1));

  // config register codes
  typedef enum logic [IdxW-1:0] {
    CFG_K_ROW_A = 3'd0,
    CFG_K_ROW_B = 3'd1,
    CFG_K_ROW_C = 3'd2,
    CFG_P_ROW_A = 3'd3,
    CFG_P_ROW_B = 3'd4,
    CFG_P_ROW_C = 3'd5
  } cfg_idx_e;

  // reset values: intrinsic identity, pose [I | 0]
  localparam logic [KRowW-1:0] KResetA = KRowW'(256);
  localparam logic [KRowW-1:0] KResetB = KRowW'(256) << KW;
  localparam logic [KRowW-1:0] KResetC = KRowW'(256) << (2 * KW);
  localparam logic [CfgW-1:0]  PResetA = CfgW'(1024);
  localparam logic [CfgW-1:0]  PResetB = CfgW'(1024) << PoseW;
  localparam logic [CfgW-1:0]  PResetC = CfgW'(1024) << (2 * PoseW);

  // homogeneous image point
  typedef struct packed {
    logic signed [HW-1:0] h0;
    logic signed [HW-1:0] h1;
    logic signed [HW-1:0] h2;
  } img_t;

  // queue status toward the back part
  typedef struct packed {
    logic valid;
    img_t item;
  } q_out_t;

endpackage

`default_nettype wire

[rtl/pinhole_point_projection_top.sv]
// ----------------------------------------------------------------------------
// pinhole_point_projection_top
// Projects homogeneous object points through pose and intrinsic matrices
// to rounded, saturated pixel coordinates.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_stall_o  point_x/y/z/w_i
//  out      output     out_valid_o / out_stall_i pixel_u_o, pixel_v_o, depth_zero_o
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  one point per cycle sustained while results are not stalled; the path is 4 front
//  stages, the queue and 22 back stages (20 of them the one-bit-per-stage divider)
//  the 8-entry queue lets the front take points while results are stalled
//  reset restores identity intrinsics and the [I | 0] pose
//  cfg writes are always ready and take effect on the next cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pinhole_point_projection_top (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  signed [ppp_pkg::PtW-1:0]    point_x_i,
  input  wire  signed [ppp_pkg::PtW-1:0]    point_y_i,
  input  wire  signed [ppp_pkg::PtW-1:0]    point_z_i,
  input  wire  signed [ppp_pkg::PtW-1:0]    point_w_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic signed [ppp_pkg::PixW-1:0]   pixel_u_o,
  output logic signed [ppp_pkg::PixW-1:0]   pixel_v_o,
  output logic                              depth_zero_o,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire         [ppp_pkg::IdxW-1:0]   cfg_index_i,
  input  wire         [ppp_pkg::CfgW-1:0]   cfg_data_i
);
  import ppp_pkg::*;

  logic   push, pop;
  img_t   item;
  q_out_t q;

  assign cfg_ready_o = 1'b1;

  // front: config registers and matrix products
  ppp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .point_w_i   (point_w_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_pop_i     (pop),
    .push_o      (push),
    .item_o      (item)
  );

  // queue between the two parts
  ppp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .pop_i  (pop),
    .q_o    (q)
  );

  // back: division and saturation
  ppp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_i          (q),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_u_o    (pixel_u_o),
    .pixel_v_o    (pixel_v_o),
    .depth_zero_o (depth_zero_o)
  );

endmodule

`default_nettype wire

[rtl/ppp_front.sv]
// ----------------------------------------------------------------------------
// ppp_front
// Holds the pose and intrinsic registers and runs the two matrix products
// in four registered stages. Admits a point only when queue space is reserved.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_front (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  signed [ppp_pkg::PtW-1:0]    point_x_i,
  input  wire  signed [ppp_pkg::PtW-1:0]    point_y_i,
  input  wire  signed [ppp_pkg::PtW-1:0]    point_z_i,
  input  wire  signed [ppp_pkg::PtW-1:0]    point_w_i,
  input  wire                               cfg_valid_i,
  input  wire         [ppp_pkg::IdxW-1:0]   cfg_index_i,
  input  wire         [ppp_pkg::CfgW-1:0]   cfg_data_i,
  input  wire                               q_pop_i,
  output logic                              push_o,
  output ppp_pkg::img_t                     item_o
);
  import ppp_pkg::*;

  logic [CfgW-1:0]  pose_q [3];
  logic [KRowW-1:0] k_q    [3];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             acc;

  logic                    v1_q, v2_q, v3_q, v4_q;
  logic signed [Pr1W-1:0]  pr1_q [3][4];
  logic signed [Pr1W-1:0]  pr1_d [3][4];
  logic signed [CamW-1:0]  cam_q [3];
  logic signed [CamW-1:0]  cam_d [3];
  logic signed [Pr2W-1:0]  pr2_q [3][3];
  logic signed [Pr2W-1:0]  pr2_d [3][3];
  logic signed [HW-1:0]    img_q [3];
  logic signed [HW-1:0]    img_d [3];
  logic signed [PtW-1:0]   pt [4];

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;
  assign pt[3] = point_w_i;

  // credit count: points admitted but not yet popped from the queue
  assign in_stall_o = (cnt_q == CntW'(QDepth));
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    cnt_d = cnt_q;
    if (acc && !q_pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!acc && q_pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // stage 1: pose products
  always_comb begin
    logic signed [Pr1W-1:0] ea;
    logic signed [Pr1W-1:0] eb;
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 4; j++) begin
        ea = $signed(pose_q[r][PoseW*j +: PoseW]);
        eb = pt[j];
        pr1_d[r][j] = ea * eb;
      end
    end
  end

  // stage 2: row sums, round half away from zero to Q.10
  always_comb begin
    logic signed [Sum1W-1:0] s;
    logic [Sum1W-1:0]        m;
    logic [Sum1W-1:0]        rm;
    for (int r = 0; r < 3; r++) begin
      s = Sum1W'(pr1_q[r][0]) + Sum1W'(pr1_q[r][1])
        + Sum1W'(pr1_q[r][2]) + Sum1W'(pr1_q[r][3]);
      m = s[Sum1W-1] ? Sum1W'(-s) : Sum1W'(s);
      rm = (m + Sum1W'(512)) >> 10;
      cam_d[r] = s[Sum1W-1] ? -$signed(CamW'(rm)) : $signed(CamW'(rm));
    end
  end

  // stage 3: intrinsic products
  always_comb begin
    logic signed [Pr2W-1:0] ea;
    logic signed [Pr2W-1:0] eb;
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        ea = $signed(k_q[r][KW*j +: KW]);
        eb = cam_q[j];
        pr2_d[r][j] = ea * eb;
      end
    end
  end

  // stage 4: image point sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      img_d[r] = HW'(pr2_q[r][0]) + HW'(pr2_q[r][1]) + HW'(pr2_q[r][2]);
    end
  end

  // control: config registers, credit count, stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q[0]    <= KResetA;
      k_q[1]    <= KResetB;
      k_q[2]    <= KResetC;
      pose_q[0] <= PResetA;
      pose_q[1] <= PResetB;
      pose_q[2] <= PResetC;
      cnt_q     <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      v1_q  <= acc;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_K_ROW_A: k_q[0]    <= cfg_data_i[KRowW-1:0];
          CFG_K_ROW_B: k_q[1]    <= cfg_data_i[KRowW-1:0];
          CFG_K_ROW_C: k_q[2]    <= cfg_data_i[KRowW-1:0];
          CFG_P_ROW_A: pose_q[0] <= cfg_data_i;
          CFG_P_ROW_B: pose_q[1] <= cfg_data_i;
          CFG_P_ROW_C: pose_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    pr1_q <= pr1_d;
    cam_q <= cam_d;
    pr2_q <= pr2_d;
    img_q <= img_d;
  end

  assign push_o     = v4_q;
  assign item_o.h0  = img_q[0];
  assign item_o.h1  = img_q[1];
  assign item_o.h2  = img_q[2];

endmodule

`default_nettype wire

[rtl/ppp_queue.sv]
// ----------------------------------------------------------------------------
// ppp_queue
// Short fifo of image points between the front and back parts. The front
// reserves space before admitting a point, so a push never finds it full.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  ppp_pkg::img_t      item_i,
  input  wire                pop_i,
  output ppp_pkg::q_out_t    q_o
);
  import ppp_pkg::*;

  img_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QAw'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QAw'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = mem_q[rd_q];

endmodule

`default_nettype wire

[rtl/ppp_back.sv]
// ----------------------------------------------------------------------------
// ppp_back
// Divides both image rows by the depth row with half-away rounding, one
// quotient bit per stage, then saturates into the output register (zero on zero depth).
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_back (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  ppp_pkg::q_out_t                   q_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic signed [ppp_pkg::PixW-1:0]   pixel_u_o,
  output logic signed [ppp_pkg::PixW-1:0]   pixel_v_o,
  output logic                              depth_zero_o
);
  import ppp_pkg::*;

  typedef struct packed {
    logic          zero;
    logic          neg0;
    logic          neg1;
    logic          ovf0;
    logic          ovf1;
    logic [RW-1:0] r0;
    logic [RW-1:0] r1;
    logic [NW-1:0] d;
    logic [QW-1:0] q0;
    logic [QW-1:0] q1;
  } div_t;

  logic                   en;
  logic                   vld_q [QW+1];
  div_t                   st_q  [QW+1];
  div_t                   st_d  [QW+1];
  logic                   out_valid_q;
  logic signed [PixW-1:0] u_q, v_q, u_d, v_d;
  logic                   z_q;

  // whole back pipeline holds while a finished result is stalled
  assign en      = !(out_valid_q && out_stall_i);
  assign q_pop_o = en && q_i.valid;

  // entry: magnitudes, rounding offset, overflow check
  always_comb begin
    logic [HW-1:0] m0, m1, dm;
    logic [NW-1:0] n0, n1;
    m0 = q_i.item.h0[HW-1] ? HW'(-q_i.item.h0) : HW'(q_i.item.h0);
    m1 = q_i.item.h1[HW-1] ? HW'(-q_i.item.h1) : HW'(q_i.item.h1);
    dm = q_i.item.h2[HW-1] ? HW'(-q_i.item.h2) : HW'(q_i.item.h2);
    n0 = {m0, 1'b0} + NW'(dm);
    n1 = {m1, 1'b0} + NW'(dm);
    st_d[0].zero = (q_i.item.h2 == '0);
    st_d[0].neg0 = q_i.item.h0[HW-1] ^ q_i.item.h2[HW-1];
    st_d[0].neg1 = q_i.item.h1[HW-1] ^ q_i.item.h2[HW-1];
    st_d[0].d    = {dm, 1'b0};
    st_d[0].r0   = RW'(n0);
    st_d[0].r1   = RW'(n1);
    st_d[0].ovf0 = RW'(n0) >= (RW'({dm, 1'b0}) << QW);
    st_d[0].ovf1 = RW'(n1) >= (RW'({dm, 1'b0}) << QW);
    st_d[0].q0   = '0;
    st_d[0].q1   = '0;
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    always_comb begin
      logic [RW-1:0] t;
      t = RW'(st_q[k].d) << B;
      st_d[k+1] = st_q[k];
      if (st_q[k].r0 >= t) begin
        st_d[k+1].r0    = st_q[k].r0 - t;
        st_d[k+1].q0[B] = 1'b1;
      end
      if (st_q[k].r1 >= t) begin
        st_d[k+1].r1    = st_q[k].r1 - t;
        st_d[k+1].q1[B] = 1'b1;
      end
    end
  end

  // sign and saturation
  always_comb begin
    div_t f;
    f = st_q[QW];
    if (f.neg0) begin
      u_d = (f.ovf0 || f.q0 > PixMinMag) ? -$signed(PixMinMag) : -$signed(f.q0);
    end else begin
      u_d = (f.ovf0 || f.q0 > PixMaxMag) ? $signed(PixMaxMag) : $signed(f.q0);
    end
    if (f.neg1) begin
      v_d = (f.ovf1 || f.q1 > PixMinMag) ? -$signed(PixMinMag) : -$signed(f.q1);
    end else begin
      v_d = (f.ovf1 || f.q1 > PixMaxMag) ? $signed(PixMaxMag) : $signed(f.q1);
    end
    if (f.zero) begin
      u_d = '0;
      v_d = '0;
    end
  end

  // stage valids and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QW; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= q_i.valid;
      for (int k = 0; k < QW; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
      out_valid_q <= vld_q[QW];
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= QW; k++) begin
        st_q[k] <= st_d[k];
      end
      u_q <= u_d;
      v_q <= v_d;
      z_q <= st_q[QW].zero;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_u_o    = u_q;
  assign pixel_v_o    = v_q;
  assign depth_zero_o = z_q;

endmodule

`default_nettype wire

[rtl/ppp_check.sv]
// ----------------------------------------------------------------------------
// ppp_check
// Port-level checks on the point projector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_check (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               in_stall_o,
  input wire                               out_valid_o,
  input wire                               out_stall_i,
  input wire  signed [ppp_pkg::PixW-1:0]   pixel_u_o,
  input wire  signed [ppp_pkg::PixW-1:0]   pixel_v_o,
  input wire                               depth_zero_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its pixels
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_u_o) && $stable(pixel_v_o))
    else $error("stalled result changed");

  // zero depth gives zero coordinates
  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && depth_zero_o |-> pixel_u_o == '0 && pixel_v_o == '0)
    else $error("zero depth with nonzero pixels");

  // no result and no input stall right after reset
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("block not idle after reset");

endmodule

bind pinhole_point_projection_top ppp_check u_check (.*);

`default_nettype wire
